// ===== rtl/core/cpsd_pkg.sv =====
// Shared types, codes and decode functions for the playback sample decoder.
// Used by every module under rtl/core; depends on nothing else.
package cpsd_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	// Sample format codes as held in the format register.
	localparam logic [2:0] FMT_U8     = 3'd0;
	localparam logic [2:0] FMT_S16_LE = 3'd1;
	localparam logic [2:0] FMT_S16_BE = 3'd2;
	localparam logic [2:0] FMT_MULAW  = 3'd3;
	localparam logic [2:0] FMT_ALAW   = 3'd4;
	localparam logic [2:0] FMT_ADPCM  = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_STEREO = 2'd1;
	localparam logic [1:0] REG_MUTE   = 2'd2;

	// Kinds of work passed from the front end to the back end.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_PCM   = 2'd1;
	localparam logic [1:0] KIND_ADPCM = 2'd2;

	localparam logic [6:0] STEP_MAX = 7'd88;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               last_of_byte;
	} out_item_t;

	typedef struct packed {
		logic [2:0] sample_format;
		logic       stereo_mode;
		logic       mute_output;
	} cfg_t;

	// One unit of work: a complete PCM frame (oldest byte in the low lane),
	// an ADPCM byte, or a bare restart.
	typedef struct packed {
		logic [1:0]  kind;
		logic        restart;
		logic [31:0] bytes;
	} work_t;

	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0]         sp;
	} adpcm_state_t;

	localparam logic [14:0] STEP_SIZE [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
		15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
		15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
		15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
		15'd27086, 15'd29794, 15'd32767
	};

	function automatic logic signed [15:0] dec_u8(logic [7:0] b);
		return {~b[7], b[6:0], 8'h00};
	endfunction

	function automatic logic signed [15:0] dec_mulaw(logic [7:0] b);
		logic [7:0]  u;
		logic [15:0] mag;
		u   = ~b;
		mag = (16'({u[3:0], 3'b000}) + 16'h0084) << u[6:4];
		return u[7] ? (16'h0084 - mag) : (mag - 16'h0084);
	endfunction

	function automatic logic signed [15:0] dec_alaw(logic [7:0] b);
		logic [7:0]  a;
		logic [15:0] mag;
		a = b ^ 8'h55;
		if (a[6:4] == 3'd0) begin
			mag = {8'h00, a[3:0], 4'h8};
		end else begin
			mag = (16'({a[3:0], 4'h0}) | 16'h0108) << (a[6:4] - 3'd1);
		end
		return a[7] ? mag : (16'd0 - mag);
	endfunction

	// One IMA ADPCM nibble: returns the updated predictor and step pointer.
	function automatic adpcm_state_t adpcm_decode(adpcm_state_t s, logic [3:0] nib);
		adpcm_state_t       r;
		logic [6:0]         sp;
		logic [7:0]         ni;
		logic [14:0]        step;
		logic [18:0]        prod;
		logic [15:0]        diff;
		logic signed [17:0] sum;
		sp   = (s.sp > STEP_MAX) ? STEP_MAX : s.sp;
		step = STEP_SIZE[sp];
		if (!nib[2]) begin
			ni = (sp == 7'd0) ? 8'd0 : 8'(sp) - 8'd1;
		end else begin
			ni = 8'(sp) + 8'({nib[1:0], 1'b0}) + 8'd2;
		end
		if (ni > 8'(STEP_MAX)) begin
			ni = 8'(STEP_MAX);
		end
		prod = 19'({nib[2:0], 1'b1}) * 19'(step);
		diff = prod[18:3];
		if (nib[3]) begin
			sum = 18'(s.pred) - $signed({2'b00, diff});
		end else begin
			sum = 18'(s.pred) + $signed({2'b00, diff});
		end
		if (sum < -18'sd32768) begin
			r.pred = 16'sh8000;
		end else if (sum > 18'sd32767) begin
			r.pred = 16'sh7FFF;
		end else begin
			r.pred = sum[15:0];
		end
		r.sp = ni[6:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/cpsd_front.sv =====
// Front end: takes stream bytes, applies restart to the byte assembly and
// turns complete frames, ADPCM bytes and restarts into work for the queue. Uses cpsd_pkg.
module cpsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  cpsd_pkg::cfg_t    cfg,
	input  logic              byte_valid,
	input  cpsd_pkg::in_item_t byte_data,
	input  logic              queue_full,
	output logic              byte_stall,
	output logic              push,
	output cpsd_pkg::work_t   push_work
);

	logic [1:0] held_q;
	logic [7:0] held_byte_q [0:2];

	logic [1:0]  held_eff;
	logic [1:0]  need_m1;
	logic        wide;
	logic        fmt_bad;
	logic        fmt_adpcm;
	logic        complete;
	logic        accept;
	logic [31:0] frame;
	logic [1:0]  idx;

	assign byte_stall = queue_full;
	assign accept     = byte_valid && !queue_full;

	assign fmt_bad   = cfg.sample_format > cpsd_pkg::FMT_ADPCM;
	assign fmt_adpcm = cfg.sample_format == cpsd_pkg::FMT_ADPCM;
	assign wide      = (cfg.sample_format == cpsd_pkg::FMT_S16_LE) ||
	                   (cfg.sample_format == cpsd_pkg::FMT_S16_BE);
	assign need_m1   = wide ? (cfg.stereo_mode ? 2'd3 : 2'd1) : (cfg.stereo_mode ? 2'd1 : 2'd0);
	assign held_eff  = byte_data.restart ? 2'd0 : held_q;
	assign complete  = held_eff >= need_m1;

	// The frame is the newest held bytes followed by the current byte.
	always_comb begin
		frame = '0;
		for (int i = 0; i < 4; i++) begin
			idx = held_eff - need_m1 + 2'(i);
			if (2'(i) < need_m1) begin
				unique case (idx)
					2'd0: frame[8*i +: 8] = held_byte_q[0];
					2'd1: frame[8*i +: 8] = held_byte_q[1];
					2'd2: frame[8*i +: 8] = held_byte_q[2];
					default: frame[8*i +: 8] = 8'h00;
				endcase
			end else begin
				frame[8*i +: 8] = byte_data.data_byte;
			end
		end
	end

	always_comb begin
		push_work.restart = byte_data.restart;
		push_work.bytes   = frame;
		if (fmt_bad) begin
			push_work.kind = cpsd_pkg::KIND_NONE;
		end else if (fmt_adpcm) begin
			push_work.kind  = cpsd_pkg::KIND_ADPCM;
			push_work.bytes = {24'h000000, byte_data.data_byte};
		end else if (complete) begin
			push_work.kind = cpsd_pkg::KIND_PCM;
		end else begin
			push_work.kind = cpsd_pkg::KIND_NONE;
		end
	end

	assign push = accept && (byte_data.restart || push_work.kind != cpsd_pkg::KIND_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
		end else if (accept) begin
			if (fmt_bad) begin
				held_q <= held_eff;
			end else if (fmt_adpcm || complete) begin
				held_q <= 2'd0;
			end else begin
				held_q <= held_eff + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !fmt_bad && !fmt_adpcm && !complete) begin
			held_byte_q[held_eff] <= byte_data.data_byte;
		end
	end

endmodule

// ===== rtl/core/cpsd_queue.sv =====
// Short work queue between the front end and the back end.
// Flip-flop storage, one push and one pop per cycle. Uses cpsd_pkg.
module cpsd_queue #(
	parameter int unsigned DEPTH = cpsd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cpsd_pkg::work_t push_work,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output cpsd_pkg::work_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cpsd_pkg::work_t  entry_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_work;
		end
	end

endmodule

// ===== rtl/core/cpsd_back.sv =====
// Back end: decodes queued work into stereo frames, keeps the ADPCM state
// and drives the output register. Uses cpsd_pkg.
module cpsd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cpsd_pkg::cfg_t      cfg,
	input  logic                work_valid,
	input  cpsd_pkg::work_t     work,
	output logic                pop,
	output logic                frame_valid,
	input  logic                frame_stall,
	output cpsd_pkg::out_item_t frame_data
);

	cpsd_pkg::adpcm_state_t st_q [0:1];
	logic                   phase_q;
	logic                   frame_valid_q;
	cpsd_pkg::out_item_t    frame_q;

	logic                   out_free;
	logic                   load;
	logic                   is_adpcm;
	logic                   is_pcm;
	logic                   mono_first;
	cpsd_pkg::adpcm_state_t in_a, in_b, res_a, res_b;
	logic [7:0]             b0, b1, b2, b3;
	logic signed [15:0]     pcm_l, pcm_r, new_l, new_r;
	logic                   new_last;

	assign out_free   = !frame_valid_q || !frame_stall;
	assign is_adpcm   = work.kind == cpsd_pkg::KIND_ADPCM;
	assign is_pcm     = work.kind == cpsd_pkg::KIND_PCM;
	assign mono_first = is_adpcm && !cfg.stereo_mode && !phase_q;

	assign load = work_valid && out_free && (is_adpcm || is_pcm);
	// A bare restart leaves at once; a mono ADPCM byte stays for its second frame.
	assign pop  = work_valid && ((work.kind == cpsd_pkg::KIND_NONE) ||
	              (load && !mono_first));

	assign b0 = work.bytes[7:0];
	assign b1 = work.bytes[15:8];
	assign b2 = work.bytes[23:16];
	assign b3 = work.bytes[31:24];

	// Channel 0 uses the low nibble, or the high one on the second mono frame.
	assign in_a  = (work.restart && !phase_q) ? '0 : st_q[0];
	assign in_b  = work.restart ? '0 : st_q[1];
	assign res_a = cpsd_pkg::adpcm_decode(in_a, phase_q ? b0[7:4] : b0[3:0]);
	assign res_b = cpsd_pkg::adpcm_decode(in_b, b0[7:4]);

	always_comb begin
		unique case (cfg.sample_format)
			cpsd_pkg::FMT_U8: begin
				pcm_l = cpsd_pkg::dec_u8(b0);
				pcm_r = cpsd_pkg::dec_u8(b1);
			end
			cpsd_pkg::FMT_S16_LE: begin
				pcm_l = {b1, b0};
				pcm_r = {b3, b2};
			end
			cpsd_pkg::FMT_S16_BE: begin
				pcm_l = {b0, b1};
				pcm_r = {b2, b3};
			end
			cpsd_pkg::FMT_MULAW: begin
				pcm_l = cpsd_pkg::dec_mulaw(b0);
				pcm_r = cpsd_pkg::dec_mulaw(b1);
			end
			default: begin
				pcm_l = cpsd_pkg::dec_alaw(b0);
				pcm_r = cpsd_pkg::dec_alaw(b1);
			end
		endcase
	end

	always_comb begin
		if (is_adpcm) begin
			new_l    = res_a.pred;
			new_r    = cfg.stereo_mode ? res_b.pred : res_a.pred;
			new_last = !mono_first;
		end else begin
			new_l    = pcm_l;
			new_r    = cfg.stereo_mode ? pcm_r : pcm_l;
			new_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
			phase_q       <= 1'b0;
			st_q[0]       <= '0;
			st_q[1]       <= '0;
		end else begin
			if (load) begin
				frame_valid_q <= 1'b1;
			end else if (!frame_stall) begin
				frame_valid_q <= 1'b0;
			end
			if (load && is_adpcm && !cfg.stereo_mode) begin
				phase_q <= !phase_q;
			end
			if (load && is_adpcm) begin
				st_q[0] <= res_a;
				if (cfg.stereo_mode) begin
					st_q[1] <= res_b;
				end else if (work.restart && !phase_q) begin
					st_q[1] <= '0;
				end
			end else if (work_valid && work.restart && (pop || load)) begin
				st_q[0] <= '0;
				st_q[1] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q.left_sample  <= cfg.mute_output ? 16'sd0 : new_l;
			frame_q.right_sample <= cfg.mute_output ? 16'sd0 : new_r;
			frame_q.last_of_byte <= new_last;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_data  = frame_q;

endmodule

// ===== rtl/core/codec_playback_sample_decoder_top.sv =====
// Top level of the playback sample decoder: configuration registers and the
// front end, work queue and back end. Uses cpsd_pkg, cpsd_front, cpsd_queue, cpsd_back.
//
//   Channel   Signals                          Carries
//   byte      byte_valid, byte_stall, byte_data  one stream byte and its restart flag
//   frame     frame_valid, frame_stall, frame_data left and right samples, last-of-byte
//   config    cfg_wr_en, cfg_index, cfg_wdata  register writes, no read-back
//
// A byte is taken every cycle while the work queue has room. Each PCM frame and
// each stereo ADPCM byte gives one output frame; a mono ADPCM byte gives two,
// one per nibble, since its second nibble needs the predictor left by the first.
// Bytes that only fill the assembly store produce no frame of their own.
// Reset clears the configuration to format 0, mono, muted, and empties the
// assembly store, the queue, the ADPCM state and the output register.
// A stall on the frame side holds the output register and backs up into the
// queue; the byte side stalls only when the queue is full.
module codec_playback_sample_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = cpsd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  cpsd_pkg::in_item_t  byte_data,
	output logic                frame_valid,
	input  logic                frame_stall,
	output cpsd_pkg::out_item_t frame_data,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [2:0]          cfg_wdata
);

	cpsd_pkg::cfg_t  cfg_q;
	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_not_empty;
	cpsd_pkg::work_t push_work;
	cpsd_pkg::work_t head_work;

	// Writes to an index outside the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format <= cpsd_pkg::FMT_U8;
			cfg_q.stereo_mode   <= 1'b0;
			cfg_q.mute_output   <= 1'b1;
		end else if (cfg_wr_en) begin
			if (cfg_index == cpsd_pkg::REG_FORMAT) begin
				cfg_q.sample_format <= cfg_wdata;
			end
			if (cfg_index == cpsd_pkg::REG_STEREO) begin
				cfg_q.stereo_mode <= cfg_wdata[0];
			end
			if (cfg_index == cpsd_pkg::REG_MUTE) begin
				cfg_q.mute_output <= cfg_wdata[0];
			end
		end
	end

	cpsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (byte_valid),
		.byte_data  (byte_data),
		.queue_full (queue_full),
		.byte_stall (byte_stall),
		.push       (push),
		.push_work  (push_work)
	);

	cpsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_work (push_work),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head      (head_work)
	);

	cpsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.work_valid  (queue_not_empty),
		.work        (head_work),
		.pop         (pop),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_data  (frame_data)
	);

endmodule
